// ----- sv/hldrs_pkg.sv -----
// ----------------------------------------------------------------------------
// hldrs_pkg
// Shared types and constants for the Hensel limb divider with right shift.
// ----------------------------------------------------------------------------
package hldrs_pkg;

  // Port field widths
  localparam int FIELD_W = 64;
  localparam int DATA_W  = 64;
  localparam int SHIFT_W = 6;

  // Register decode: 64-bit registers at 8-byte spacing, index in paddr[3]
  localparam int CFG_AW = 4;
  localparam logic REG_DIVISOR = 1'b0;
  localparam logic REG_SHIFT   = 1'b1;

  // Newton iterations for the 2-adic inverse
  localparam int NEWTON_ITERS = 6;
  localparam int ITER_W       = 3;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MS_Q  = 2'd0,  // diff * inverse       -> quotient limb
    MS_H  = 2'd1,  // quotient * divisor   -> high product
    MS_NT = 2'd2,  // divisor * inverse    -> newton term
    MS_NI = 2'd3   // inverse * (2 - term) -> next inverse
  } mul_sel_t;

  typedef struct packed {
    logic     cap_in;
    logic     load_x;
    logic     lone;
    logic     sub;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     wr_q;
    logic     wr_hp;
    logic     wr_t;
    logic     wr_inv;
    logic     emit;
    logic     fin;
  } dp_cmd_t;

  typedef struct packed {
    logic pend_valid;
    logic cur_last;
    logic mul_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/hldrs_mul.sv -----
// ----------------------------------------------------------------------------
// hldrs_mul
// Iterative multiplier: one half-by-half partial product per cycle, summed
// into a full double-width product. Start restarts it at any time.
// ----------------------------------------------------------------------------
module hldrs_mul #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int H    = (W + 1) / 2;
  localparam int EW   = 2 * H;
  localparam int ACCW = 4 * H;
  localparam logic [2:0] LAST_CNT = 3'd4;

  logic [EW-1:0]   a_r;
  logic [EW-1:0]   b_r;
  logic [ACCW-1:0] acc;
  logic [EW-1:0]   pp_reg;
  logic [1:0]      pp_idx;
  logic [2:0]      cnt;
  logic            busy;

  logic [H-1:0]    a_half;
  logic [H-1:0]    b_half;
  logic [EW-1:0]   pp_next;
  logic [ACCW-1:0] pp_sh;

  assign a_half  = cnt[0] ? a_r[EW-1:H] : a_r[H-1:0];
  assign b_half  = cnt[1] ? b_r[EW-1:H] : b_r[H-1:0];
  assign pp_next = EW'(a_half) * EW'(b_half);

  always_comb begin
    case (pp_idx)
      2'd0:       pp_sh = ACCW'(pp_reg);
      2'd1, 2'd2: pp_sh = ACCW'(pp_reg) << H;
      2'd3:       pp_sh = ACCW'(pp_reg) << (2 * H);
      default:    pp_sh = ACCW'(pp_reg);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == LAST_CNT) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // each partial product is added into the product in the cycle after it is registered
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= EW'(a);
      b_r <= EW'(b);
      acc <= '0;
    end else if (busy) begin
      if (cnt != LAST_CNT) begin
        pp_reg <= pp_next;
        pp_idx <= cnt[1:0];
      end
      if (cnt != 3'd0) begin
        acc <= acc + pp_sh;
      end
    end
  end

  assign prod = acc[2*W-1:0];

endmodule

// ----- sv/hldrs_dp.sv -----
// ----------------------------------------------------------------------------
// hldrs_dp
// Datapath: config registers, pending limb, shifter, borrow/subtract,
// shared multiplier, newton inverse terms and the result register.
// ----------------------------------------------------------------------------
module hldrs_dp #(
  parameter int LIMB_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hldrs_pkg::dp_cmd_t            cmd,
  output hldrs_pkg::dp_stat_t           stat,
  input  logic [hldrs_pkg::FIELD_W-1:0] in_limb,
  input  logic                          in_last,
  input  logic                          div_wr,
  input  logic                          shift_wr,
  input  logic [hldrs_pkg::DATA_W-1:0]  wdata,
  output logic [LIMB_BITS-1:0]          cfg_divisor,
  output logic [hldrs_pkg::SHIFT_W-1:0] cfg_shift,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [LIMB_BITS-1:0]          out_quot,
  output logic                          out_final,
  output logic [LIMB_BITS-1:0]          out_rem
);

  localparam int L  = LIMB_BITS;
  localparam int SW = $clog2(LIMB_BITS);
  localparam int XW = hldrs_pkg::SHIFT_W + 1;

  logic [L-1:0] divisor;
  logic [hldrs_pkg::SHIFT_W-1:0] shift_r;
  logic [L-1:0] inv;
  logic [L-1:0] pend;
  logic         pend_valid;
  logic [L-1:0] hp;
  logic         borrow;
  logic [L-1:0] cur;
  logic         cur_last;
  logic [L-1:0] x;
  logic [L-1:0] diff;
  logic [L-1:0] q;
  logic [L-1:0] ntmp;

  logic [XW-1:0]  sh_ext;
  logic [SW-1:0]  s_eff;
  logic [2*L-1:0] pair_sh;
  logic [L-1:0]   lone_x;
  logic [L-1:0]   t_sum;
  logic [L-1:0]   mul_a;
  logic [L-1:0]   mul_b;
  logic [2*L-1:0] prod;
  logic           mul_done;
  logic [L-1:0]   two;

  // effective shift saturates at LIMB_BITS-1
  assign sh_ext  = {1'b0, shift_r};
  assign s_eff   = (sh_ext >= XW'(L)) ? SW'(L - 1) : shift_r[SW-1:0];
  assign pair_sh = {cur, pend} >> s_eff;
  assign lone_x  = cur >> s_eff;
  assign t_sum   = hp + L'(borrow);
  assign two     = L'(2);

  always_comb begin
    case (cmd.mul_sel)
      hldrs_pkg::MS_Q:  begin mul_a = diff;    mul_b = inv;     end
      hldrs_pkg::MS_H:  begin mul_a = q;       mul_b = divisor; end
      hldrs_pkg::MS_NT: begin mul_a = divisor; mul_b = inv;     end
      hldrs_pkg::MS_NI: begin mul_a = inv;     mul_b = ntmp;    end
      default:          begin mul_a = diff;    mul_b = inv;     end
    endcase
  end

  hldrs_mul #(.W(L)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor    <= L'(1);
      shift_r    <= '0;
      inv        <= L'(1);
      pend       <= '0;
      pend_valid <= 1'b0;
      hp         <= '0;
      borrow     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (div_wr) begin
        divisor <= wdata[L-1:0] | L'(1);
        inv     <= wdata[L-1:0] | L'(1);
      end
      if (shift_wr) shift_r <= wdata[hldrs_pkg::SHIFT_W-1:0];
      if (cmd.wr_inv) inv <= prod[L-1:0];
      if (cmd.sub) borrow <= (t_sum > x);
      if (cmd.wr_hp) hp <= prod[2*L-1:L];
      if (cmd.fin) begin
        if (cur_last) begin
          pend       <= '0;
          pend_valid <= 1'b0;
          hp         <= '0;
          borrow     <= 1'b0;
        end else begin
          pend       <= cur;
          pend_valid <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cur      <= in_limb[L-1:0];
      cur_last <= in_last;
    end
    if (cmd.load_x) x <= cmd.lone ? lone_x : pair_sh[L-1:0];
    if (cmd.sub) diff <= x - t_sum;
    if (cmd.wr_q) q <= prod[L-1:0];
    if (cmd.wr_t) ntmp <= two - prod[L-1:0];
    if (cmd.emit) begin
      out_quot  <= q;
      out_final <= cmd.lone;
      out_rem   <= cmd.lone ? t_sum : '0;
    end
  end

  assign stat.pend_valid = pend_valid;
  assign stat.cur_last   = cur_last;
  assign stat.mul_done   = mul_done;
  assign stat.out_free   = !out_valid || !out_stall;

  assign cfg_divisor = divisor;
  assign cfg_shift   = shift_r;

endmodule

// ----- sv/hldrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// hldrs_ctrl
// Controller: parks a non-last first limb; takes later limbs through shift,
// subtract, two multiplies, result beat; newton inverse after a divisor write.
// ----------------------------------------------------------------------------
module hldrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  input  logic                div_wr,
  input  hldrs_pkg::dp_stat_t stat,
  output logic                in_stall,
  output hldrs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_INV_T = 9'b000000010,
    S_INV_I = 9'b000000100,
    S_SHIFT = 9'b000001000,
    S_SUB   = 9'b000010000,
    S_MULQ  = 9'b000100000,
    S_MULH  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   lone, lone_next;
  logic   mstarted, mstarted_next;
  logic [hldrs_pkg::ITER_W-1:0] iter, iter_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || div_wr;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.lone      = lone;
    cmd.mul_sel   = hldrs_pkg::MS_Q;
    state_next    = state;
    lone_next     = lone;
    mstarted_next = mstarted;
    iter_next     = iter;
    if (div_wr) begin
      state_next    = S_INV_T;
      iter_next     = '0;
      mstarted_next = 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd.cap_in = 1'b1;
            if (stat.pend_valid) begin
              state_next = S_SHIFT;
              lone_next  = 1'b0;
            end else if (in_last) begin
              state_next = S_SHIFT;
              lone_next  = 1'b1;
            end else begin
              state_next = S_FIN;
            end
          end
        end
        S_INV_T: begin
          cmd.mul_sel = hldrs_pkg::MS_NT;
          if (!mstarted) begin
            cmd.mul_start = 1'b1;
            mstarted_next = 1'b1;
          end else if (stat.mul_done) begin
            cmd.wr_t      = 1'b1;
            mstarted_next = 1'b0;
            state_next    = S_INV_I;
          end
        end
        S_INV_I: begin
          cmd.mul_sel = hldrs_pkg::MS_NI;
          if (!mstarted) begin
            cmd.mul_start = 1'b1;
            mstarted_next = 1'b1;
          end else if (stat.mul_done) begin
            cmd.wr_inv    = 1'b1;
            mstarted_next = 1'b0;
            if (iter == hldrs_pkg::ITER_W'(hldrs_pkg::NEWTON_ITERS - 1)) begin
              state_next = S_IDLE;
            end else begin
              iter_next  = iter + 1'b1;
              state_next = S_INV_T;
            end
          end
        end
        S_SHIFT: begin
          cmd.load_x = 1'b1;
          state_next = S_SUB;
        end
        S_SUB: begin
          cmd.sub    = 1'b1;
          state_next = S_MULQ;
        end
        S_MULQ: begin
          cmd.mul_sel = hldrs_pkg::MS_Q;
          if (!mstarted) begin
            cmd.mul_start = 1'b1;
            mstarted_next = 1'b1;
          end else if (stat.mul_done) begin
            cmd.wr_q      = 1'b1;
            mstarted_next = 1'b0;
            state_next    = S_MULH;
          end
        end
        S_MULH: begin
          cmd.mul_sel = hldrs_pkg::MS_H;
          if (!mstarted) begin
            cmd.mul_start = 1'b1;
            mstarted_next = 1'b1;
          end else if (stat.mul_done) begin
            cmd.wr_hp     = 1'b1;
            mstarted_next = 1'b0;
            state_next    = S_EMIT;
          end
        end
        S_EMIT: begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            if (!lone && stat.cur_last) begin
              // pending limb done, now the last limb on its own
              state_next = S_SHIFT;
              lone_next  = 1'b1;
            end else begin
              state_next = S_FIN;
            end
          end
        end
        S_FIN: begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      lone     <= 1'b0;
      mstarted <= 1'b0;
      iter     <= '0;
    end else begin
      state    <= state_next;
      lone     <= lone_next;
      mstarted <= mstarted_next;
      iter     <= iter_next;
    end
  end

endmodule

// ----- sv/hensel_limb_divide_right_shift_top.sv -----
// ----------------------------------------------------------------------------
// hensel_limb_divide_right_shift_top
// Right-shifts a multi-limb number and divides it 2-adically by an odd limb.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | in        | in_valid/in_stall  | limb, is_last
//  out     | out       | out_valid/out_stall| quotient_limb, final_res, remainder
//  cfg     | in        | APB, pready = 1    | 0x0 divisor, 0x8 shift_amount
//
//  An ordinary limb is paced by the two dependent LIMB_BITS products done
//  on one shared half-width multiplier (4 partial products each); the first
//  limb of a longer number is only kept as pending; the last is worked twice.
//  A divisor write runs the newton inverse (12 products) with in_stall
//  high. rst is synchronous; after it divisor and inverse are 1. One item
//  is in work at a time; a result beat waits in the output register while
//  out_stall is high, and the next result then waits in the emit step.
// ----------------------------------------------------------------------------
module hensel_limb_divide_right_shift_top #(
  parameter int LIMB_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // input limbs
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hldrs_pkg::FIELD_W-1:0]  limb,
  input  logic                           is_last,
  // quotient limbs
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hldrs_pkg::FIELD_W-1:0]  quotient_limb,
  output logic                           final_res,
  output logic [hldrs_pkg::FIELD_W-1:0]  remainder,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hldrs_pkg::CFG_AW-1:0]   paddr,
  input  logic [hldrs_pkg::DATA_W-1:0]   pwdata,
  output logic [hldrs_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int FW = hldrs_pkg::FIELD_W;
  localparam int DW = hldrs_pkg::DATA_W;

  hldrs_pkg::dp_cmd_t  cmd;
  hldrs_pkg::dp_stat_t stat;

  logic                          cfg_wr;
  logic                          div_wr;
  logic                          shift_wr;
  logic                          reg_sel;
  logic [LIMB_BITS-1:0]          cfg_divisor;
  logic [hldrs_pkg::SHIFT_W-1:0] cfg_shift;
  logic [LIMB_BITS-1:0]          out_quot;
  logic [LIMB_BITS-1:0]          out_rem;

  // register index sits in the top address bit (8-byte spacing)
  assign pready   = 1'b1;
  assign reg_sel  = paddr[hldrs_pkg::CFG_AW-1];
  assign cfg_wr   = psel && penable && pwrite;
  assign div_wr   = cfg_wr && (reg_sel == hldrs_pkg::REG_DIVISOR);
  assign shift_wr = cfg_wr && (reg_sel == hldrs_pkg::REG_SHIFT);
  assign prdata   = (reg_sel == hldrs_pkg::REG_SHIFT) ? DW'(cfg_shift)
                                                      : DW'(cfg_divisor);

  hldrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (is_last),
    .div_wr   (div_wr),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  hldrs_dp #(.LIMB_BITS(LIMB_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_limb     (limb),
    .in_last     (is_last),
    .div_wr      (div_wr),
    .shift_wr    (shift_wr),
    .wdata       (pwdata),
    .cfg_divisor (cfg_divisor),
    .cfg_shift   (cfg_shift),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_quot    (out_quot),
    .out_final   (final_res),
    .out_rem     (out_rem)
  );

  assign quotient_limb = FW'(out_quot);
  assign remainder     = FW'(out_rem);

endmodule
